/* rtl/lkp_pkg.sv */
// package for the lru key pool: sizes, register map and sequencer states
package lkp_pkg;
    localparam int MaxEntries = 128;
    localparam int KeyBits    = 32;
    localparam int SlotBits   = $clog2(MaxEntries);
    localparam int CountBits  = SlotBits + 1;
    localparam int DefaultCap = 100;
    localparam int CapDef     = (DefaultCap > MaxEntries) ? MaxEntries : DefaultCap;
    localparam logic [0:0] RegCapacity = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_AGE,
        S_OUT
    } t_state;
endpackage

/* rtl/lru_key_pool.sv */
// lru key pool top level: key and rank memories with a scan sequencer
//
// channel  direction  payload
// s_axis   in         tdata[31:0] lookup_key
// m_axis   out        tdata[40:0] hit, slot, evicted, evicted_key
// apb      in/out     pool_capacity at address 0
//
// one lookup makes one pass over the key and rank memories to find the key and the
// least recent slot, then one pass over the rank memory to age entries, one read port each.
// reset is synchronous; it clears the count and control state and sets the capacity to
// its default; the memories are not cleared. a stalled result holds in the output register
// while the next lookup runs; that lookup waits in its last state until the register is free.
module lru_key_pool (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // lookup_key
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // hit, slot[6:0], evicted, evicted_key[31:0], zero pad
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lkp_pkg::*;

    logic [KeyBits-1:0]  r_keys [MaxEntries];
    logic [SlotBits-1:0] r_rank [MaxEntries];
    logic [KeyBits-1:0]  r_kq;
    logic [SlotBits-1:0] r_rq;

    t_state r_state, n_state;
    logic [7:0]           r_cap;
    logic [CountBits-1:0] r_count;
    logic [CountBits-1:0] r_idx;     // address issued
    logic [CountBits-1:0] r_pidx;    // address of data in r_kq/r_rq
    logic                 r_pv;
    logic [KeyBits-1:0]   r_key;
    logic                 r_found;
    logic [SlotBits-1:0]  r_fslot;
    logic [SlotBits-1:0]  r_wslot;
    logic [SlotBits-1:0]  r_worst;
    logic [KeyBits-1:0]   r_wkey;
    logic                 r_hit, r_evict;
    logic [SlotBits-1:0]  r_slot;
    logic [SlotBits-1:0]  r_srank;
    logic [KeyBits-1:0]   r_okey;
    logic                 r_grow;
    logic                 r_ovalid;
    logic [47:0]          r_odata;

    logic [CountBits-1:0] w_cap;
    logic                 w_cfg_wr;
    logic                 w_out_free;

    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && (paddr == RegCapacity);
    assign prdata = (paddr == RegCapacity) ? {24'd0, r_cap} : 32'd0;
    assign w_cap = (r_cap < 8'd2 || 32'(r_cap) > MaxEntries) ? CountBits'(CapDef)
                                                           : CountBits'(r_cap);
    assign w_out_free = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (s_axis_tvalid && s_axis_tready) n_state = S_SCAN;
            S_SCAN:   if (r_idx >= r_count && !r_pv) n_state = S_DECIDE;
            S_DECIDE: n_state = S_AGE;
            S_AGE:    if (r_idx >= r_count && !r_pv && !r_grow) n_state = S_OUT;
            S_OUT:    if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_kq <= r_keys[r_idx[SlotBits-1:0]];
        r_rq <= r_rank[r_idx[SlotBits-1:0]];
        if (r_state == S_OUT) begin
            r_keys[r_slot] <= r_key;
        end
        if (r_state == S_AGE && r_pv) begin
            if (r_pidx[SlotBits-1:0] == r_slot) begin
                r_rank[r_pidx[SlotBits-1:0]] <= '0;
            end else if (r_rq < r_srank) begin
                r_rank[r_pidx[SlotBits-1:0]] <= r_rq + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= 8'(DefaultCap);
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_pv     <= 1'b0;
            r_idx    <= '0;
        end else begin
            r_state <= n_state;
            if (w_cfg_wr) r_cap <= pwdata[7:0];
            if (r_state == S_OUT && w_out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_idx   <= '0;
                    r_pv    <= 1'b0;
                    r_key   <= s_axis_tdata[KeyBits-1:0];
                    r_found <= 1'b0;
                    r_worst <= '0;
                    r_wslot <= '0;
                end
                S_SCAN: begin
                    r_pv   <= r_idx < r_count;
                    r_pidx <= r_idx;
                    if (r_idx < r_count) r_idx <= r_idx + 1'b1;
                    if (r_pv) begin
                        if (!r_found && r_kq == r_key) begin
                            r_found <= 1'b1;
                            r_fslot <= r_pidx[SlotBits-1:0];
                            r_srank <= r_rq;
                        end
                        if (r_rq >= r_worst) begin
                            r_worst <= r_rq;
                            r_wslot <= r_pidx[SlotBits-1:0];
                            r_wkey  <= r_kq;
                        end
                    end
                end
                S_DECIDE: begin
                    r_idx <= '0;
                    r_pv  <= 1'b0;
                    r_grow <= 1'b0;
                    if (r_found) begin
                        r_hit <= 1'b1; r_evict <= 1'b0;
                        r_slot <= r_fslot; r_okey <= '0;
                    end else if (r_count >= w_cap && r_count != '0) begin
                        r_hit <= 1'b0; r_evict <= 1'b1;
                        r_slot <= r_wslot; r_okey <= r_wkey; r_srank <= r_worst;
                    end else begin
                        r_hit <= 1'b0; r_evict <= 1'b0;
                        r_slot <= r_count[SlotBits-1:0]; r_okey <= '0;
                        r_srank <= r_count[SlotBits-1:0];
                        r_grow <= 1'b1;
                    end
                end
                S_AGE: begin
                    if (r_grow) begin
                        r_count <= r_count + 1'b1;
                        r_grow  <= 1'b0;
                    end
                    r_pv   <= r_idx < r_count + CountBits'(r_grow);
                    r_pidx <= r_idx;
                    if (r_idx < r_count + CountBits'(r_grow)) r_idx <= r_idx + 1'b1;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_odata <= {7'd0, 32'(r_okey), r_evict, 7'(r_slot), r_hit};
                    end
                end
                default: ;
            endcase
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= MaxEntries) else $error("entry count above depth");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !m_axis_tready |=> r_ovalid && $stable(r_odata))
        else $error("result changed while stalled");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !s_axis_tready) else $error("accepted while busy");
    a_evict_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[8]))
        else $error("hit and eviction together");
endmodule
